// ===== rtl/core/tlfq_pkg.sv =====
// Shared types and constants of the three-level feedback queue scheduler.
package tlfq_pkg;

    localparam int QUEUE_DEPTH_DEF   = 128;
    localparam int DURATION_BITS_DEF = 16;

    localparam int ID_W     = 8;
    localparam int TIME_W   = 16;
    localparam int LEVEL_W  = 2;
    localparam int OUTC_W   = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [TIME_W-1:0] HIGH_ALLOT_RST   = 16'd2;
    localparam logic [TIME_W-1:0] MIDDLE_ALLOT_RST = 16'd4;
    localparam logic [TIME_W-1:0] LOW_ALLOT_RST    = 16'd8;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_ALLOT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIDDLE_ALLOT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_ALLOT    = 2'd2;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    localparam logic [LEVEL_W-1:0] LVL_LOW    = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_MIDDLE = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_HIGH   = 2'd2;

    localparam logic [OUTC_W-1:0] OC_ADDED     = 3'd0;
    localparam logic [OUTC_W-1:0] OC_REJECTED  = 3'd1;
    localparam logic [OUTC_W-1:0] OC_COMPLETED = 3'd2;
    localparam logic [OUTC_W-1:0] OC_MOVED     = 3'd3;
    localparam logic [OUTC_W-1:0] OC_REQUEUED  = 3'd4;
    localparam logic [OUTC_W-1:0] OC_DROPPED   = 3'd5;
    localparam logic [OUTC_W-1:0] OC_IDLE      = 3'd6;
    localparam logic [OUTC_W-1:0] OC_LOST      = 3'd7;

    typedef struct packed {
        logic              kind;
        logic [ID_W-1:0]   task_id;
        logic [TIME_W-1:0] yield_time;
        logic [TIME_W-1:0] duration;
    } tlfq_in_t;

    typedef struct packed {
        logic [ID_W-1:0]    served_id;
        logic [LEVEL_W-1:0] level;
        logic [OUTC_W-1:0]  outcome;
        logic [TIME_W-1:0]  remaining;
    } tlfq_out_t;

endpackage

// ===== rtl/core/tlfq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/three_level_feedback_queue_scheduler_top.sv =====
// Top level of the three-level feedback queue scheduler.
//
// Input channel task_valid/task_ready carries task_item: kind add puts a task
// at the tail of the high queue, kind step serves the head of the highest
// non-empty queue against that level's allotment and pushes it on if needed.
// Every item gives exactly one result item on result_valid/result_ready.
// Config channel cfg_valid/cfg_ready writes the three allotments (index 0
// high, 1 middle, 2 low; other indexes are ignored); cfg_ready is always high,
// writes are expected only while the block is idle.
// An item is accepted in the idle state and its result is loaded into the
// output register from the execute state; no new item is taken until that
// result is loaded. A step reads the head entry from the queue RAM in the
// accept cycle, and the registered read data is used in the execute state,
// where the modified task is written to its new queue as the result is loaded.
// If the receiver stalls, the finished result waits in the execute state and
// nothing is written until the output register frees; no new item is taken.
// Reset clears pointers, fill counts and the output valid flag and reloads the
// allotment reset values at once; queue RAM contents are not cleared, fill
// counts guard every read, so there is no clearing pass.
module three_level_feedback_queue_scheduler_top #(
    parameter int QUEUE_DEPTH   = tlfq_pkg::QUEUE_DEPTH_DEF,
    parameter int DURATION_BITS = tlfq_pkg::DURATION_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               task_valid,
    output logic                               task_ready,
    input  tlfq_pkg::tlfq_in_t                 task_item,
    output logic                               result_valid,
    input  logic                               result_ready,
    output tlfq_pkg::tlfq_out_t                result_item,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tlfq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tlfq_pkg::TIME_W-1:0]        cfg_data
);

    import tlfq_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int DB = DURATION_BITS;
    localparam int EW = ID_W + TIME_W + DB;
    localparam int XW = (DB > TIME_W) ? DB : TIME_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    tlfq_in_t          item_reg, item_next;
    logic [LEVEL_W-1:0] lvl_reg, lvl_next;
    logic              empty_reg, empty_next;
    logic [PW-1:0]     head_reg [3];
    logic [PW-1:0]     head_next [3];
    logic [PW-1:0]     tail_reg [3];
    logic [PW-1:0]     tail_next [3];
    logic [CW-1:0]     count_reg [3];
    logic [CW-1:0]     count_next [3];
    logic [TIME_W-1:0] allot_reg [3];
    logic [TIME_W-1:0] allot_next [3];
    logic              out_valid_reg, out_valid_next;
    tlfq_out_t         out_item_reg, out_item_next;

    logic [2:0]        ram_we;
    logic [2:0]        ram_re;
    logic [EW-1:0]     ram_wdata;
    logic [EW-1:0]     ram_rdata [3];

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        if (p == PW'(QUEUE_DEPTH - 1))
            return '0;
        else
            return p + PW'(1);
    endfunction

    assign task_ready   = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

    always_comb
    begin
        logic               go;
        logic               push_en;
        logic [LEVEL_W-1:0] push_lvl;
        logic [EW-1:0]      push_entry;
        tlfq_out_t          res;
        logic [ID_W-1:0]    t_id;
        logic [TIME_W-1:0]  t_yt;
        logic [DB-1:0]      t_dur;
        logic [DB-1:0]      new_dur;
        logic [DB-1:0]      add_dur;
        logic [TIME_W-1:0]  allot;
        logic [LEVEL_W-1:0] target;
        logic               tgt_full;

        state_next     = state_reg;
        item_next      = item_reg;
        lvl_next       = lvl_reg;
        empty_next     = empty_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        allot_next     = allot_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        ram_re         = '0;
        ram_we         = '0;

        go         = !out_valid_reg || result_ready;
        push_en    = 1'b0;
        push_lvl   = LVL_HIGH;
        push_entry = '0;
        res        = '0;

        t_id    = ram_rdata[lvl_reg][EW-1 -: ID_W];
        t_yt    = ram_rdata[lvl_reg][DB +: TIME_W];
        t_dur   = ram_rdata[lvl_reg][DB-1:0];
        allot   = allot_reg[lvl_reg];
        add_dur = DB'(item_reg.duration);
        new_dur = DB'(XW'(t_dur) - XW'(allot));
        target  = (lvl_reg == LVL_LOW) ? LVL_LOW : lvl_reg - LEVEL_W'(1);
        tgt_full = (count_reg[target] == CW'(QUEUE_DEPTH));

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_HIGH_ALLOT:   allot_next[LVL_HIGH]   = cfg_data;
                REG_MIDDLE_ALLOT: allot_next[LVL_MIDDLE] = cfg_data;
                REG_LOW_ALLOT:    allot_next[LVL_LOW]    = cfg_data;
                default: ;
            endcase
        end

        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (task_valid)
                begin
                    item_next  = task_item;
                    state_next = ST_EXEC;
                    empty_next = 1'b0;
                    if (task_item.kind == KIND_STEP)
                    begin
                        // pop now; the entry arrives from the RAM next cycle
                        if (count_reg[LVL_HIGH] != '0)
                            lvl_next = LVL_HIGH;
                        else if (count_reg[LVL_MIDDLE] != '0)
                            lvl_next = LVL_MIDDLE;
                        else if (count_reg[LVL_LOW] != '0)
                            lvl_next = LVL_LOW;
                        else
                            empty_next = 1'b1;
                        if (count_reg[lvl_next] != '0)
                        begin
                            ram_re[lvl_next]     = 1'b1;
                            head_next[lvl_next]  = ptr_inc(head_reg[lvl_next]);
                            count_next[lvl_next] = count_reg[lvl_next] - CW'(1);
                        end
                    end
                end
            end
            ST_EXEC:
            begin
                if (item_reg.kind == KIND_ADD)
                begin
                    res.served_id = item_reg.task_id;
                    res.level     = LVL_HIGH;
                    res.remaining = TIME_W'(add_dur);
                    push_lvl      = LVL_HIGH;
                    push_entry    = {item_reg.task_id, item_reg.yield_time, add_dur};
                    if (count_reg[LVL_HIGH] == CW'(QUEUE_DEPTH))
                        res.outcome = OC_REJECTED;
                    else
                    begin
                        res.outcome = OC_ADDED;
                        push_en     = 1'b1;
                    end
                end
                else if (empty_reg)
                begin
                    res.served_id = '0;
                    res.level     = LVL_LOW;
                    res.outcome   = OC_IDLE;
                    res.remaining = '0;
                end
                else
                begin
                    res.served_id = t_id;
                    res.level     = lvl_reg;
                    push_lvl      = target;
                    if (t_yt < allot)
                    begin
                        if (XW'(t_dur) <= XW'(allot))
                        begin
                            res.outcome   = OC_COMPLETED;
                            res.remaining = '0;
                        end
                        else
                        begin
                            res.remaining = TIME_W'(new_dur);
                            push_entry    = {t_id, t_yt, new_dur};
                            if (tgt_full)
                                res.outcome = OC_LOST;
                            else
                            begin
                                push_en     = 1'b1;
                                res.outcome = (lvl_reg == LVL_LOW) ? OC_REQUEUED : OC_MOVED;
                            end
                        end
                    end
                    else
                    begin
                        res.remaining = TIME_W'(t_dur);
                        push_entry    = {t_id, t_yt, t_dur};
                        if (lvl_reg == LVL_LOW)
                            res.outcome = OC_DROPPED;
                        else if (tgt_full)
                            res.outcome = OC_LOST;
                        else
                        begin
                            push_en     = 1'b1;
                            res.outcome = OC_MOVED;
                        end
                    end
                end

                // nothing is committed until the output register can take the item
                if (go)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = res;
                    state_next     = ST_IDLE;
                    if (push_en)
                    begin
                        ram_we[push_lvl]     = 1'b1;
                        tail_next[push_lvl]  = ptr_inc(tail_reg[push_lvl]);
                        count_next[push_lvl] = count_reg[push_lvl] + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        ram_wdata = push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg             <= ST_IDLE;
            lvl_reg               <= LVL_LOW;
            empty_reg             <= 1'b0;
            head_reg              <= '{default: '0};
            tail_reg              <= '{default: '0};
            count_reg             <= '{default: '0};
            allot_reg[LVL_HIGH]   <= HIGH_ALLOT_RST;
            allot_reg[LVL_MIDDLE] <= MIDDLE_ALLOT_RST;
            allot_reg[LVL_LOW]    <= LOW_ALLOT_RST;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lvl_reg       <= lvl_next;
            empty_reg     <= empty_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            allot_reg     <= allot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        out_item_reg <= out_item_next;
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_queue
        tlfq_ram #(
            .WIDTH (EW),
            .DEPTH (QUEUE_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (ram_we[i]),
            .waddr (tail_reg[i]),
            .wdata (ram_wdata),
            .re    (ram_re[i]),
            .raddr (head_reg[i]),
            .rdata (ram_rdata[i])
        );
    end

endmodule

// ===== rtl/core/tlfq_checker.sv =====
// Port-level assertions for the scheduler top level, bound to it.
module tlfq_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                task_valid,
    input logic                task_ready,
    input logic                result_valid,
    input logic                result_ready,
    input tlfq_pkg::tlfq_out_t result_item
);

    import tlfq_pkg::*;

    // a stalled result must hold
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_item))
        else $error("result item changed while stalled");

    // one item in flight: ready drops after every accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        task_valid && task_ready |=> !task_ready)
        else $error("item accepted back to back");

    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_item.outcome == OC_IDLE |->
            result_item.served_id == '0 && result_item.remaining == '0 &&
            result_item.level == LVL_LOW)
        else $error("idle result carries data");

    a_add_level: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_item.outcome == OC_ADDED ||
            result_item.outcome == OC_REJECTED) |-> result_item.level == LVL_HIGH)
        else $error("add result not on high level");

    a_completed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_item.outcome == OC_COMPLETED |->
            result_item.remaining == '0)
        else $error("completed task shows remaining work");

endmodule

bind three_level_feedback_queue_scheduler_top tlfq_checker u_tlfq_checker (.*);

// ===== bench/three_level_feedback_queue_scheduler_top_tb.sv =====
// Self-checking testbench for the three-level feedback queue scheduler top level.
module three_level_feedback_queue_scheduler_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tlfq_pkg::*;

    localparam int unsigned FIFO_DEPTH  = QUEUE_DEPTH_DEF;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] yt;
        logic [TIME_W-1:0] dur;
    } queued_job_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 task_valid = 1'b0;
    logic                 task_ready;
    tlfq_in_t             task_item = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    tlfq_out_t            result_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TIME_W-1:0]    cfg_data = '0;

    // scheduler mirror: three level queues and allotments indexed by level
    queued_job_t       high_fifo[$];
    queued_job_t       middle_fifo[$];
    queued_job_t       low_fifo[$];
    logic [TIME_W-1:0] allot [0:2] = '{LOW_ALLOT_RST, MIDDLE_ALLOT_RST, HIGH_ALLOT_RST};

    tlfq_out_t   pending_results[$];
    tlfq_out_t   got_result;
    tlfq_out_t   want_result;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned gap_odds = 4;
    int unsigned stall_left = 0;

    three_level_feedback_queue_scheduler_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .task_valid   (task_valid),
        .task_ready   (task_ready),
        .task_item    (task_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    function automatic int unsigned fifo_fill(input logic [LEVEL_W-1:0] lvl);
        case (lvl)
            LVL_HIGH:   return high_fifo.size();
            LVL_MIDDLE: return middle_fifo.size();
            default:    return low_fifo.size();
        endcase
    endfunction

    function automatic bit fifo_push(input logic [LEVEL_W-1:0] lvl, input queued_job_t job);
        if (fifo_fill(lvl) >= FIFO_DEPTH)
            return 1'b0;
        case (lvl)
            LVL_HIGH:   high_fifo.push_back(job);
            LVL_MIDDLE: middle_fifo.push_back(job);
            default:    low_fifo.push_back(job);
        endcase
        return 1'b1;
    endfunction

    function automatic queued_job_t fifo_pop(input logic [LEVEL_W-1:0] lvl);
        case (lvl)
            LVL_HIGH:   return high_fifo.pop_front();
            LVL_MIDDLE: return middle_fifo.pop_front();
            default:    return low_fifo.pop_front();
        endcase
    endfunction

    function automatic int unsigned jobs_waiting();
        return high_fifo.size() + middle_fifo.size() + low_fifo.size();
    endfunction

    // Result of one accepted item; updates the mirrored queues.
    function automatic tlfq_out_t predict_outcome(input tlfq_in_t it);
        tlfq_out_t          r;
        queued_job_t        job;
        logic [LEVEL_W-1:0] lvl;
        logic [LEVEL_W-1:0] dest;
        logic [TIME_W-1:0]  a;
        r = '0;
        if (it.kind == KIND_ADD)
        begin
            job.id  = it.task_id;
            job.yt  = it.yield_time;
            job.dur = it.duration;
            r.served_id = it.task_id;
            r.level     = LVL_HIGH;
            r.remaining = it.duration;
            r.outcome   = fifo_push(LVL_HIGH, job) ? OC_ADDED : OC_REJECTED;
            return r;
        end
        if (fifo_fill(LVL_HIGH) != 0)
            lvl = LVL_HIGH;
        else if (fifo_fill(LVL_MIDDLE) != 0)
            lvl = LVL_MIDDLE;
        else if (fifo_fill(LVL_LOW) != 0)
            lvl = LVL_LOW;
        else
        begin
            r.level   = LVL_LOW;
            r.outcome = OC_IDLE;
            return r;
        end
        job  = fifo_pop(lvl);
        a    = allot[lvl];
        dest = (lvl == LVL_LOW) ? LVL_LOW : lvl - 2'd1;
        r.served_id = job.id;
        r.level     = lvl;
        if (job.yt < a)
        begin
            if (job.dur <= a)
            begin
                r.outcome = OC_COMPLETED;
                return r;
            end
            job.dur     = job.dur - a;
            r.remaining = job.dur;
            // the pop has freed a slot, so a low requeue always fits
            if (fifo_push(dest, job))
                r.outcome = (lvl == LVL_LOW) ? OC_REQUEUED : OC_MOVED;
            else
                r.outcome = OC_LOST;
        end
        else
        begin
            r.remaining = job.dur;
            if (lvl == LVL_LOW)
                r.outcome = OC_DROPPED;
            else
                r.outcome = fifo_push(dest, job) ? OC_MOVED : OC_LOST;
        end
        return r;
    endfunction

    // Values clustered round an allotment, plus extremes and full-range noise.
    function automatic logic [TIME_W-1:0] pick_time(input logic [TIME_W-1:0] near);
        int unsigned base;
        base = 32'(near);
        case ($urandom_range(0, 5))
            0:       return TIME_W'($urandom_range(0, 65535));
            1:       return TIME_W'(base + $urandom_range(0, 2) - 1);
            2:       return TIME_W'(base * $urandom_range(1, 4));
            3:       return TIME_W'($urandom_range(0, 15));
            4:       return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            default: return TIME_W'($urandom_range(0, 3 * base + 3));
        endcase
    endfunction

    function automatic tlfq_in_t random_item(input int unsigned add_pct);
        tlfq_in_t it;
        it.kind       = ($urandom_range(0, 99) < add_pct) ? KIND_ADD : KIND_STEP;
        it.task_id    = ID_W'($urandom_range(0, 255));
        it.yield_time = pick_time(allot[$urandom_range(0, 2)]);
        it.duration   = pick_time(allot[$urandom_range(0, 2)]);
        return it;
    endfunction

    // Valid is left high after acceptance so back-to-back items need no re-raise.
    task automatic send_item(input tlfq_in_t it);
        int unsigned n;
        if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0)
        begin
            n = $urandom_range(1, 6);
            task_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        task_valid <= 1'b1;
        task_item  <= it;
        @(posedge clk);
        while (!task_ready) @(posedge clk);
        pending_results.push_back(predict_outcome(it));
    endtask

    task automatic add_task(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] yt,
                            input logic [TIME_W-1:0] dur);
        tlfq_in_t it;
        it.kind       = KIND_ADD;
        it.task_id    = id;
        it.yield_time = yt;
        it.duration   = dur;
        send_item(it);
    endtask

    task automatic step_once();
        send_item(random_item(0));
    endtask

    task automatic settle();
        task_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic drain_by_steps();
        while (jobs_waiting() != 0) step_once();
        step_once();
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_HIGH_ALLOT:   allot[LVL_HIGH] = val;
            REG_MIDDLE_ALLOT: allot[LVL_MIDDLE] = val;
            REG_LOW_ALLOT:    allot[LVL_LOW] = val;
            default:          ;
        endcase
    endtask

    task automatic set_allotments(input logic [TIME_W-1:0] h, input logic [TIME_W-1:0] m,
                                  input logic [TIME_W-1:0] l);
        write_reg(REG_HIGH_ALLOT, h);
        write_reg(REG_MIDDLE_ALLOT, m);
        write_reg(REG_LOW_ALLOT, l);
        cfg_valid <= 1'b0;
    endtask

    // Reset allotments 2/4/8: idle, completion, each move, requeue and drop.
    task automatic test_directed_paths();
        step_once();
        add_task(8'h00, 16'h0000, 16'h0000);
        step_once();
        add_task(8'hFF, 16'h0001, 16'hFFFF);
        repeat (3) step_once();
        add_task(8'h5A, 16'hFFFF, 16'h0007);
        repeat (4) step_once();
        // yield equal to the allotment is not below it
        add_task(8'hA5, 16'h0002, 16'h0003);
        repeat (2) step_once();
        add_task(8'h33, 16'h0007, 16'h0008);
        repeat (4) step_once();
        settle();
    endtask

    // Full high queue rejects adds; full lower queues lose tasks moving down.
    task automatic test_queue_limits();
        int unsigned k;
        set_allotments(16'd2, 16'd4, 16'hFFFF);
        for (k = 0; k < FIFO_DEPTH; k++)
            add_task(ID_W'($urandom_range(0, 255)), 16'hFFFF, pick_time(16'd8));
        add_task(8'hFF, 16'h0000, 16'hFFFF);
        add_task(8'h00, 16'hFFFF, 16'h0000);
        repeat (FIFO_DEPTH) step_once();
        add_task(8'h81, 16'hFFFF, 16'h1234);
        step_once();
        repeat (FIFO_DEPTH) step_once();
        add_task(8'h7E, 16'hFFFF, 16'h4321);
        repeat (2) step_once();
        drain_by_steps();
        settle();
    endtask

    task automatic test_config_extremes();
        int unsigned s;
        int unsigned k;
        write_reg(REG_NONE, 16'h1234);
        for (s = 0; s < 3; s++)
        begin
            case (s)
                0:       set_allotments(16'h0000, 16'h0000, 16'h0000);
                1:       set_allotments(16'hFFFF, 16'hFFFF, 16'hFFFF);
                default: set_allotments(16'h0001, 16'h8000, 16'h7FFF);
            endcase
            for (k = 0; k < 6; k++)
                add_task(ID_W'($urandom_range(0, 255)), pick_time(allot[k % 3]),
                         pick_time(allot[k % 3]));
            drain_by_steps();
            settle();
        end
    endtask

    task automatic test_random_traffic();
        int unsigned seg;
        int unsigned k;
        int unsigned add_pct;
        for (seg = 0; seg < 5; seg++)
        begin
            case ($urandom_range(0, 3))
                0: set_allotments(TIME_W'($urandom_range(1, 16)), TIME_W'($urandom_range(1, 16)),
                                  TIME_W'($urandom_range(1, 16)));
                1: set_allotments(TIME_W'($urandom_range(0, 65535)),
                                  TIME_W'($urandom_range(0, 65535)),
                                  TIME_W'($urandom_range(0, 65535)));
                2: set_allotments(16'h0000, 16'hFFFF, TIME_W'($urandom_range(0, 300)));
                default: set_allotments(HIGH_ALLOT_RST, MIDDLE_ALLOT_RST, LOW_ALLOT_RST);
            endcase
            case ($urandom_range(0, 2))
                0:       gap_odds = 0;
                1:       gap_odds = 3;
                default: gap_odds = 6;
            endcase
            // heavier add mixes push the high queue into rejection
            add_pct = $urandom_range(35, 70);
            for (k = 0; k < 200; k++)
                send_item(random_item(add_pct));
            settle();
        end
    endtask

    task automatic test_steady_stream();
        int unsigned k;
        gap_odds = 0;
        for (k = 0; k < 200; k++)
            send_item(random_item(50));
        settle();
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            got_result = result_item;
            if (pending_results.size() == 0)
            begin
                $error("result item with none expected: served_id %0d outcome %0d",
                       got_result.served_id, got_result.outcome);
                fail_count++;
            end
            else
            begin
                want_result = pending_results.pop_front();
                compare_field("served_id", 32'(want_result.served_id),
                              32'(got_result.served_id));
                compare_field("level", 32'(want_result.level), 32'(got_result.level));
                compare_field("outcome", 32'(want_result.outcome), 32'(got_result.outcome));
                compare_field("remaining", 32'(want_result.remaining),
                              32'(got_result.remaining));
            end
        end
    end

    // receiver back-pressure in random bursts
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (stall_left == 0 && gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0)
                stall_left = $urandom_range(1, 6);
            if (stall_left != 0)
            begin
                result_ready <= 1'b0;
                stall_left--;
            end
            else
                result_ready <= 1'b1;
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_paths();
        test_queue_limits();
        test_config_extremes();
        test_random_traffic();
        test_steady_stream();
        if (fail_count == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/tlfq_pkg.sv
rtl/core/tlfq_ram.sv
rtl/core/three_level_feedback_queue_scheduler_top.sv
rtl/core/tlfq_checker.sv
bench/three_level_feedback_queue_scheduler_top_tb.sv
